// ===== rtl/lcdq_pkg.sv =====
// Shared types and constants for the character-LCD command queue engine.
`timescale 1ns / 1ps

package lcdq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int NIBBLE_W = 4;
    localparam int BYTE_W   = 2 * NIBBLE_W;
    localparam int ENTRY_W  = BYTE_W + 1;
    localparam int TYPE_BIT = BYTE_W;

    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    localparam logic [1:0] CMD_ENQ_INSTR = 2'd0;
    localparam logic [1:0] CMD_ENQ_DATA  = 2'd1;
    localparam logic [1:0] CMD_TICK      = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_STROBE = 1'b1;
    localparam logic RW_WRITE    = 1'b0;
    localparam logic RW_READ     = 1'b1;
    localparam logic RS_INSTR    = 1'b0;

    typedef enum logic {
        JOB_ENQUEUE,
        JOB_TICK
    } job_kind_t;

    typedef struct packed {
        job_kind_t           kind;
        logic                entry_type;
        logic [BYTE_W-1:0]   data_byte;
        logic                busy_flag;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ2,
        ST_HIGH,
        ST_LOW
    } back_state_t;

endpackage

// ===== rtl/lcdq_if.sv =====
// Handshake channel interfaces for command items and bus/status result items.
`timescale 1ns / 1ps

interface lcdq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       busy_flag;

    modport source (output valid, output command, output data_byte, output busy_flag,
                    input ready);
    modport sink   (input valid, input command, input data_byte, input busy_flag,
                    output ready);
endinterface

interface lcdq_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic       enqueue_ok;
    logic       reg_select;
    logic       read_not_write;
    logic [3:0] nibble;
    logic       last;

    modport source (output valid, output result_kind, output enqueue_ok,
                    output reg_select, output read_not_write, output nibble,
                    output last, input ready);
    modport sink   (input valid, input result_kind, input enqueue_ok,
                    input reg_select, input read_not_write, input nibble,
                    input last, output ready);
endinterface

// ===== rtl/lcdq_front.sv =====
// Front end: accept command items, decode them into jobs, drop unused codes.
`timescale 1ns / 1ps

module lcdq_front
    import lcdq_pkg::*;
(
    lcdq_in_if.sink cmd,
    output logic    job_valid,
    input  logic    job_ready,
    output job_t    job
);

    logic is_enq;
    logic is_tick;

    assign is_enq  = (cmd.command == CMD_ENQ_INSTR) || (cmd.command == CMD_ENQ_DATA);
    assign is_tick = (cmd.command == CMD_TICK);

    // Every item waits for job space; an unused code is then taken and dropped.
    assign cmd.ready = job_ready;
    assign job_valid = cmd.valid && (is_enq || is_tick);

    always_comb
    begin
        job.kind       = is_tick ? JOB_TICK : JOB_ENQUEUE;
        job.entry_type = (cmd.command == CMD_ENQ_DATA);
        job.data_byte  = cmd.data_byte;
        job.busy_flag  = cmd.busy_flag;
    end

endmodule

// ===== rtl/lcdq_job_fifo.sv =====
// Short job queue between the front end and the bus sequencer.
`timescale 1ns / 1ps

module lcdq_job_fifo
    import lcdq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t                 slot_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_CNT_W-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != JOB_CNT_W'(JOB_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/lcdq_back.sv =====
// Back end: ring entry store and the display bus strobe sequencer.
`timescale 1ns / 1ps

module lcdq_back
    import lcdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    lcdq_out_if.source res
);

    logic [ENTRY_W-1:0]     mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]     rd_q;
    logic                   mem_we;
    logic                   mem_re;

    back_state_t            state_reg, state_next;
    logic [QUEUE_IDX_W-1:0] head_reg, head_next;
    logic [QUEUE_IDX_W-1:0] tail_reg, tail_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   busy_reg, busy_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   kind_reg, kind_next;
    logic                   ok_reg, ok_next;
    logic                   rs_reg, rs_next;
    logic                   rw_reg, rw_next;
    logic [NIBBLE_W-1:0]    nib_reg, nib_next;
    logic                   last_reg, last_next;

    logic                   out_free;
    logic                   full;
    logic                   zero_data;

    assign out_free  = !out_valid_reg || res.ready;
    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign zero_data = rd_q[TYPE_BIT] && (rd_q[BYTE_W-1:0] == '0);

    assign res.valid          = out_valid_reg;
    assign res.result_kind    = kind_reg;
    assign res.enqueue_ok     = ok_reg;
    assign res.reg_select     = rs_reg;
    assign res.read_not_write = rw_reg;
    assign res.nibble         = nib_reg;
    assign res.last           = last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[tail_reg] <= {job.entry_type, job.data_byte};
        if (mem_re)
            rd_q <= mem[head_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !res.ready;
        kind_next      = kind_reg;
        ok_next        = ok_reg;
        rs_next        = rs_reg;
        rw_next        = rw_reg;
        nib_next       = nib_reg;
        last_next      = last_reg;
        job_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && out_free)
                begin
                    job_ready = 1'b1;
                    if (job.kind == JOB_ENQUEUE)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_STATUS;
                        ok_next        = !full;
                        rs_next        = RS_INSTR;
                        rw_next        = RW_WRITE;
                        nib_next       = '0;
                        last_next      = 1'b1;
                        if (!full)
                        begin
                            mem_we     = 1'b1;
                            tail_next  = (tail_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        // First busy-flag read strobe; fetch head entry meanwhile.
                        out_valid_next = 1'b1;
                        kind_next      = KIND_STROBE;
                        ok_next        = 1'b0;
                        rs_next        = RS_INSTR;
                        rw_next        = RW_READ;
                        nib_next       = '0;
                        last_next      = 1'b0;
                        mem_re         = 1'b1;
                        busy_next      = job.busy_flag;
                        state_next     = ST_READ2;
                    end
                end
            end
            ST_READ2:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STROBE;
                    ok_next        = 1'b0;
                    rs_next        = RS_INSTR;
                    rw_next        = RW_READ;
                    nib_next       = '0;
                    if (busy_reg)
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        head_next  = (head_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        last_next  = zero_data;
                        state_next = zero_data ? ST_IDLE : ST_HIGH;
                    end
                end
            end
            ST_HIGH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STROBE;
                    ok_next        = 1'b0;
                    rs_next        = rd_q[TYPE_BIT];
                    rw_next        = RW_WRITE;
                    nib_next       = rd_q[BYTE_W-1:NIBBLE_W];
                    last_next      = 1'b0;
                    state_next     = ST_LOW;
                end
            end
            ST_LOW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_STROBE;
                    ok_next        = 1'b0;
                    rs_next        = rd_q[TYPE_BIT];
                    rw_next        = RW_WRITE;
                    nib_next       = rd_q[NIBBLE_W-1:0];
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        busy_reg <= busy_next;
        kind_reg <= kind_next;
        ok_reg   <= ok_next;
        rs_reg   <= rs_next;
        rw_reg   <= rw_next;
        nib_reg  <= nib_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/char_lcd_command_queue_engine_top.sv =====
// Top level of the character-LCD command queue engine (4-bit bus, ring queue).
`timescale 1ns / 1ps

// Channel  Dir  Payload                                              Accepted when
// -------  ---  ---------------------------------------------------  -------------------
// cmd      in   command, data_byte, busy_flag                        cmd.valid & cmd.ready
// res      out  result_kind, enqueue_ok, reg_select, read_not_write,  res.valid & res.ready
//               nibble, last
//
// An enqueue item yields one status result, registered as the item leaves the job queue.
// A tick yields up to four strobes, one per cycle unless res stalls, set by the back-end
// sequencer that drives the single output register; a tick on an empty queue yields none.
// The front takes one item per cycle until the two-entry job queue fills, so the
// front keeps accepting while the back waits on a stalled result.
// rst_n clears the queue pointers, fill count, job queue and output valid at once;
// entry contents are never cleared and are read only after being written.

module char_lcd_command_queue_engine_top
    import lcdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lcdq_in_if.sink    cmd,
    lcdq_out_if.source res
);

    // Decoded jobs from the front end into the job queue.
    logic front_valid;
    logic front_ready;
    job_t front_job;

    // Jobs out of the job queue into the bus sequencer.
    logic back_valid;
    logic back_ready;
    job_t back_job;

    lcdq_front u_front (
        .cmd       (cmd),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    lcdq_job_fifo u_job_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    lcdq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .res       (res)
    );

`ifndef SYNTH
    // A status result stands alone and drives nothing onto the bus.
    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.result_kind == KIND_STATUS) |->
            res.last && (res.read_not_write == RW_WRITE) && (res.nibble == '0)
            && (res.reg_select == RS_INSTR))
        else $error("status result malformed");

    // Busy-flag reads use the instruction register and leave the data lines at zero.
    a_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.result_kind == KIND_STROBE) && (res.read_not_write == RW_READ) |->
            (res.reg_select == RS_INSTR) && (res.nibble == '0) && !res.enqueue_ok)
        else $error("read strobe malformed");

    // A taken high nibble is followed at once by its low nibble with the same RS.
    a_low_follows_high: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready && (res.result_kind == KIND_STROBE)
        && (res.read_not_write == RW_WRITE) && !res.last |=>
            res.valid && (res.result_kind == KIND_STROBE)
            && (res.read_not_write == RW_WRITE) && res.last && $stable(res.reg_select))
        else $error("low nibble did not follow high nibble");

    // A job never leaves the job queue when it is empty.
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        back_ready |-> back_valid)
        else $error("job taken from empty queue");
`endif

endmodule

// ===== tb/char_lcd_command_queue_engine_top_tb.sv =====
// Self-checking testbench for the character-LCD command queue engine top level.
`timescale 1ns / 1ps

// The bench drives command items (enqueue instruction, enqueue character, tick,
// and the unused code) through the cmd channel, predicts every status and bus
// strobe item in its own copy of the ring queue, and checks each item that leaves
// the res channel against the oldest prediction, field by field.
//
// Flow:
//   - reset held low, then a directed table (empty queue, unused command,
//     byte extremes, busy display, zero character, instruction and data writes)
//   - a fill sweep that runs the queue into overflow, then random episodes of
//     enqueue bursts, tick bursts, full drains, refills and ignored noise items
//   - the sender idles in bursts with random gaps, the receiver stalls on its
//     own rotating pattern, and several times the sender holds until all
//     results are in

module char_lcd_command_queue_engine_top_tb;
    import lcdq_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;   // ignored by the block
    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;

    // One bus or status item as seen on the res channel.
    typedef struct packed {
        logic       kind;
        logic       ok;
        logic       rs;
        logic       rw;
        logic [3:0] nib;
        logic       last;
    } lcd_result_t;

    // Directed row: fixed_n < 0 means the predictor supplies the results,
    // otherwise fixed_n results are typed in (fa first, then fb).
    typedef struct {
        logic [1:0]  command;
        logic [7:0]  data_byte;
        logic        busy;
        int          fixed_n;
        lcd_result_t fa;
        lcd_result_t fb;
    } stim_row_t;

    localparam lcd_result_t NONE      = '0;
    localparam lcd_result_t ENQ_OK    = '{KIND_STATUS, 1'b1, RS_INSTR, RW_WRITE, 4'h0, 1'b1};
    localparam lcd_result_t RD_STROBE = '{KIND_STROBE, 1'b0, RS_INSTR, RW_READ, 4'h0, 1'b0};
    localparam lcd_result_t RD_LAST   = '{KIND_STROBE, 1'b0, RS_INSTR, RW_READ, 4'h0, 1'b1};

    localparam int DIRECTED_ROWS = 18;

    // The queue is filled with six entries, then drained by ticks with busy and
    // idle display levels in between. Rows marked -1 are writes whose nibbles
    // come from the predictor.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_TICK,      8'h00, 1'b0,  0, NONE,      NONE},     // empty queue after reset
        '{CMD_UNUSED,    8'hFF, 1'b1,  0, NONE,      NONE},     // unused code
        '{CMD_ENQ_INSTR, 8'h00, 1'b0,  1, ENQ_OK,    NONE},
        '{CMD_ENQ_DATA,  8'hFF, 1'b1,  1, ENQ_OK,    NONE},
        '{CMD_ENQ_DATA,  8'h00, 1'b0,  1, ENQ_OK,    NONE},     // zero character
        '{CMD_ENQ_INSTR, 8'hFF, 1'b1,  1, ENQ_OK,    NONE},
        '{CMD_ENQ_DATA,  8'hA5, 1'b0,  1, ENQ_OK,    NONE},
        '{CMD_ENQ_INSTR, 8'h5A, 1'b1,  1, ENQ_OK,    NONE},
        '{CMD_TICK,      8'hFF, 1'b1,  2, RD_STROBE, RD_LAST},  // display busy
        '{CMD_TICK,      8'h00, 1'b0, -1, NONE,      NONE},     // instruction 00
        '{CMD_TICK,      8'hFF, 1'b1,  2, RD_STROBE, RD_LAST},  // busy again
        '{CMD_TICK,      8'hFF, 1'b0, -1, NONE,      NONE},     // character FF
        '{CMD_TICK,      8'h00, 1'b0,  2, RD_STROBE, RD_LAST},  // zero character, no write
        '{CMD_TICK,      8'h5C, 1'b0, -1, NONE,      NONE},     // instruction FF
        '{CMD_UNUSED,    8'h00, 1'b0,  0, NONE,      NONE},     // unused code, queue busy
        '{CMD_TICK,      8'hA3, 1'b0, -1, NONE,      NONE},     // character A5
        '{CMD_TICK,      8'h00, 1'b0, -1, NONE,      NONE},     // instruction 5A
        '{CMD_TICK,      8'hFF, 1'b1,  0, NONE,      NONE}      // empty again, busy high
    };

    logic clk;
    logic rst_n;

    lcdq_in_if  cmd_if ();
    lcdq_out_if res_if ();

    char_lcd_command_queue_engine_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    // Predictor state: a private copy of the ring queue.
    logic [ENTRY_W-1:0]     entry_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] entry_queued;
    logic [QUEUE_IDX_W-1:0] head_idx;
    logic [QUEUE_IDX_W-1:0] tail_idx;
    int                     queued_count;

    lcd_result_t bus_step [$];       // results of the item just accepted
    lcd_result_t awaited_results [$];

    int  error_count   = 0;
    int  checked_count = 0;
    int  live_items    = 0;
    int  ignored_items = 0;
    int  enqueues      = 0;
    int  drops         = 0;
    int  writes        = 0;
    int  busy_reads    = 0;
    int  zero_chars    = 0;
    int  cycle_count   = 0;
    int  burst_left    = 0;
    logic sending      = 1'b0;
    logic [8:0] stall_phase = '0;

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("char_lcd_command_queue_engine_top_tb failed");
            $finish;
        end
    end

    // Receiver: rotate through always-ready, sparse random stalls, a periodic
    // stall pattern and heavy stalls with a forced hold while stall_phase[5:3] is zero.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[8:7])
            2'd0:    res_if.ready <= 1'b1;
            2'd1:    res_if.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    res_if.ready <= (stall_phase[2:0] != 3'd5) && (stall_phase[3:0] != 4'd9);
            default: res_if.ready <= ($urandom_range(0, 1) == 1) && (stall_phase[5:3] != 3'd0);
        endcase
    end

    function automatic logic [QUEUE_IDX_W-1:0] next_idx(logic [QUEUE_IDX_W-1:0] idx);
        return (idx == QUEUE_DEPTH - 1) ? '0 : idx + 1'b1;
    endfunction

    // Work out the results of one accepted command item and advance the
    // private queue. Leaves the results in bus_step, empty when ignored.
    function automatic void predict_bus_activity(logic [1:0] command, logic [7:0] data_byte,
                                                 logic busy);
        logic [ENTRY_W-1:0] entry;
        lcd_result_t        tail_res;
        bus_step.delete();
        if (command == CMD_ENQ_INSTR || command == CMD_ENQ_DATA)
        begin
            enqueues++;
            if (entry_queued[head_idx] && tail_idx == head_idx)
            begin
                // Queue full: drop the byte, report the overflow.
                bus_step.push_back('{KIND_STATUS, 1'b0, RS_INSTR, RW_WRITE, 4'h0, 1'b0});
                drops++;
            end
            else
            begin
                entry_mem[tail_idx]    = {command[0], data_byte};
                entry_queued[tail_idx] = 1'b1;
                tail_idx               = next_idx(tail_idx);
                queued_count++;
                bus_step.push_back(ENQ_OK);
            end
        end
        else if (command == CMD_TICK && entry_queued[head_idx])
        begin
            // Busy-flag read is always two read strobes on the instruction register.
            bus_step.push_back(RD_STROBE);
            bus_step.push_back(RD_STROBE);
            if (busy)
            begin
                busy_reads++;
            end
            else
            begin
                entry = entry_mem[head_idx];
                if (!entry[TYPE_BIT] || entry[BYTE_W-1:0] != '0)
                begin
                    bus_step.push_back('{KIND_STROBE, 1'b0, entry[TYPE_BIT], RW_WRITE,
                                         entry[BYTE_W-1:NIBBLE_W], 1'b0});
                    bus_step.push_back('{KIND_STROBE, 1'b0, entry[TYPE_BIT], RW_WRITE,
                                         entry[NIBBLE_W-1:0], 1'b0});
                    writes++;
                end
                else
                begin
                    // Zero character ends a string: dequeue without a write.
                    zero_chars++;
                end
                entry_queued[head_idx] = 1'b0;
                head_idx               = next_idx(head_idx);
                queued_count--;
            end
        end
        if (bus_step.size() != 0)
        begin
            tail_res      = bus_step.pop_back();
            tail_res.last = 1'b1;
            bus_step.push_back(tail_res);
        end
    endfunction

    // Hold the sender idle, lowering valid only if it is still raised.
    task automatic hold_sender();
        if (sending)
        begin
            cmd_if.valid <= 1'b0;
            sending = 1'b0;
        end
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic wait_all_results();
        hold_sender();
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Present one item, wait for the handshake, record its results, then
    // advance the burst/gap pattern.
    task automatic drive_item(logic [1:0] command, logic [7:0] data_byte, logic busy,
                              int fixed_n = -1, lcd_result_t fa = '0, lcd_result_t fb = '0);
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= command;
        cmd_if.data_byte <= data_byte;
        cmd_if.busy_flag <= busy;
        sending = 1'b1;
        do
            @(posedge clk);
        while (!cmd_if.ready);

        predict_bus_activity(command, data_byte, busy);
        if (bus_step.size() == 0)
            ignored_items++;
        else
            live_items++;
        if (fixed_n < 0)
        begin
            foreach (bus_step[i])
                awaited_results.push_back(bus_step[i]);
        end
        else
        begin
            if (fixed_n > 0)
                awaited_results.push_back(fa);
            if (fixed_n > 1)
                awaited_results.push_back(fb);
        end

        if (burst_left == 0)
        begin
            hold_sender();
            repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 24) : $urandom_range(1, 5))
                @(posedge clk);
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 48)
                                                     : $urandom_range(0, 10);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Byte values weighted toward the extremes and the zero character.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [1:0] pick_enqueue();
        return $urandom_range(0, 1) ? CMD_ENQ_DATA : CMD_ENQ_INSTR;
    endfunction

    // Check each accepted result against the oldest prediction.
    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        lcd_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual kind=%0d ok=%0d rs=%0d rw=%0d nibble=%h last=%0d",
                         $time, res_if.result_kind, res_if.enqueue_ok, res_if.reg_select,
                         res_if.read_not_write, res_if.nibble, res_if.last);
            end
            else
            begin
                want = awaited_results.pop_front();
                checked_count++;
                check_field("result_kind", want.kind, res_if.result_kind);
                check_field("enqueue_ok", want.ok, res_if.enqueue_ok);
                check_field("reg_select", want.rs, res_if.reg_select);
                check_field("read_not_write", want.rw, res_if.read_not_write);
                check_field("nibble", want.nib, res_if.nibble);
                check_field("last", want.last, res_if.last);
            end
        end
    end

    initial
    begin : stimulus
        int target;
        int k;
        int midpoint_done;

        // Known levels on every input from time zero.
        clk              = 1'b0;
        rst_n            = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.command   = CMD_ENQ_INSTR;
        cmd_if.data_byte = 8'h00;
        cmd_if.busy_flag = 1'b0;
        res_if.ready     = 1'b0;
        entry_queued     = '0;
        head_idx         = '0;
        tail_idx         = '0;
        queued_count     = 0;
        midpoint_done    = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++)
            drive_item(directed_rows[r].command, directed_rows[r].data_byte,
                       directed_rows[r].busy, directed_rows[r].fixed_n,
                       directed_rows[r].fa, directed_rows[r].fb);
        wait_all_results();

        // Fill sweep: run the queue past full so a few bytes get dropped.
        repeat (QUEUE_DEPTH - queued_count + $urandom_range(1, 3))
            drive_item(pick_enqueue(), pick_byte(), 1'($urandom_range(0, 1)));
        wait_all_results();

        // Random episodes.
        target = live_items + RANDOM_ITEMS;
        while (live_items < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    repeat ($urandom_range(1, 6))
                        drive_item(pick_enqueue(), pick_byte(), 1'($urandom_range(0, 1)));
                end
                4, 5, 6:
                begin
                    repeat ($urandom_range(1, 6))
                        drive_item(CMD_TICK, 8'($urandom_range(0, 255)),
                                   $urandom_range(0, 3) == 0);
                end
                7:
                begin
                    // Drain to empty, then one tick on the empty queue.
                    k = 0;
                    while (queued_count != 0 && k < 2 * QUEUE_DEPTH)
                    begin
                        drive_item(CMD_TICK, 8'($urandom_range(0, 255)),
                                   $urandom_range(0, 3) == 0);
                        k++;
                    end
                    drive_item(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                8:
                begin
                    // Noise: the unused code.
                    drive_item(CMD_UNUSED, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        repeat (QUEUE_DEPTH - queued_count + $urandom_range(1, 2))
                            drive_item(pick_enqueue(), pick_byte(), 1'($urandom_range(0, 1)));
                    end
                    else
                    begin
                        drive_item(pick_enqueue(), pick_byte(), 1'($urandom_range(0, 1)));
                    end
                end
            endcase

            if (!midpoint_done && live_items >= target - RANDOM_ITEMS / 2)
            begin
                midpoint_done = 1;
                wait_all_results();
            end
        end

        // Drain what is left, then give the block time to show stray items.
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d live and %0d ignored items: %0d enqueues, %0d dropped on full",
                 live_items, ignored_items, enqueues, drops);
        $display("Ticks: %0d writes, %0d busy reads, %0d zero characters; %0d results checked",
                 writes, busy_reads, zero_chars, checked_count);
        if (error_count == 0)
            $display("char_lcd_command_queue_engine_top_tb passed");
        else
            $display("char_lcd_command_queue_engine_top_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lcdq_pkg.sv
rtl/lcdq_if.sv
rtl/lcdq_front.sv
rtl/lcdq_job_fifo.sv
rtl/lcdq_back.sv
rtl/char_lcd_command_queue_engine_top.sv
tb/char_lcd_command_queue_engine_top_tb.sv
